FILE: src/assert_macros.svh
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// When pre holds, post must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: src/b64e_pkg.sv
// Types, constants and the character map of the Base64 stream encoder.
`timescale 1ns / 1ps
package b64e_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_URL_ALPHABET = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_ENABLE   = 1'd1;

   // Bytes gathered in a group.
   localparam logic [1:0] GROUP_ONE   = 2'd1;
   localparam logic [1:0] GROUP_TWO   = 2'd2;
   localparam logic [1:0] GROUP_THREE = 2'd3;
   localparam logic [1:0] CHAR_IDX_LAST = 2'd3;

   localparam logic [7:0] CHAR_PAD = 8'h3d;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       msg_last;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
      logic       msg_end;
   } rsp_word_type;

   // One group handed from the front to the back.
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] nbytes;
      logic       msg_last;
   } group_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + ({2'b00, v} - 8'd26);
      end else if (v < 6'd62) begin
         c = 8'h30 + ({2'b00, v} - 8'd52);
      end else if (v == 6'd62) begin
         c = url ? 8'h2d : 8'h2b;
      end else begin
         c = url ? 8'h5f : 8'h2f;
      end
      return c;
   endfunction

endpackage

FILE: src/b64e_queue.sv
// Short group queue between the byte front and the character back.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64e_queue
   import b64e_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_group,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output group_type head_group
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type         entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_group = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_group;
      end
   end

   `ASSERT_ALWAYS(a_no_push_when_full, clock, reset, !(push && full))
   `ASSERT_ALWAYS(a_no_pop_when_empty, clock, reset, !(pop && !head_valid))

endmodule

FILE: src/b64e_front.sv
// Byte front: gathers bytes into groups of up to three and queues them.
`timescale 1ns / 1ps
module b64e_front
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_word_type req_word,
   output logic         req_stall,
   input  logic         queue_full,
   output logic         push,
   output group_type    push_group
);

   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_first_ff, held_first_in;
   logic [7:0] held_second_ff, held_second_in;
   logic       accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      push_group.msg_last = req_word.msg_last;
      push_group.byte1    = 8'h00;
      push_group.byte2    = 8'h00;
      case (held_count_ff)
         2'd0: begin
            push_group.byte0  = req_word.data_byte;
            push_group.nbytes = GROUP_ONE;
         end
         2'd1: begin
            push_group.byte0  = held_first_ff;
            push_group.byte1  = req_word.data_byte;
            push_group.nbytes = GROUP_TWO;
         end
         default: begin
            // a count of three never arises; it behaves as two
            push_group.byte0  = held_first_ff;
            push_group.byte1  = held_second_ff;
            push_group.byte2  = req_word.data_byte;
            push_group.nbytes = GROUP_THREE;
         end
      endcase

      push = accept && ((push_group.nbytes == GROUP_THREE) || req_word.msg_last);

      held_count_in  = held_count_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      if (accept) begin
         held_count_in = push ? 2'd0 : push_group.nbytes;
         if (held_count_ff == 2'd0) begin
            held_first_in = req_word.data_byte;
         end
         if (held_count_ff == 2'd1) begin
            held_second_in = req_word.data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
      end else begin
         held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      held_first_ff  <= held_first_in;
      held_second_ff <= held_second_in;
   end

endmodule

FILE: src/b64e_back.sv
// Character back: queued groups to Base64, one char a cycle when free.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64e_back
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         url_alphabet,
   input  logic         pad_enable,
   input  logic         head_valid,
   input  group_type    head_group,
   output logic         pop,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         rsp_stall
);

   logic [1:0]   char_idx_ff, char_idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         out_free;
   logic         emit;
   logic [1:0]   last_idx;
   logic [5:0]   sextet;
   logic [7:0]   char_code;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = head_valid && out_free;
   assign last_idx = pad_enable ? CHAR_IDX_LAST : head_group.nbytes;
   assign pop      = emit && (char_idx_ff == last_idx);

   always_comb begin
      case (char_idx_ff)
         2'd0:    sextet = head_group.byte0[7:2];
         2'd1:    sextet = {head_group.byte0[1:0], head_group.byte1[7:4]};
         2'd2:    sextet = {head_group.byte1[3:0], head_group.byte2[7:6]};
         default: sextet = head_group.byte2[5:0];
      endcase
      // positions past the data of a short group are padding
      char_code = (char_idx_ff > head_group.nbytes) ? CHAR_PAD
                                                    : sextet_char(sextet, url_alphabet);

      char_idx_in  = char_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (emit) begin
         char_idx_in          = pop ? 2'd0 : char_idx_ff + 2'd1;
         rsp_valid_in         = 1'b1;
         rsp_word_in.out_char = char_code;
         rsp_word_in.run_last = pop;
         rsp_word_in.msg_end  = pop && head_group.msg_last;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_idx_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         char_idx_ff  <= char_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `ASSERT_ALWAYS(a_mid_group_has_head, clock, reset, (char_idx_ff == 2'd0) || head_valid)
   `ASSERT_ALWAYS(a_end_on_run_last, clock, reset,
                  !(rsp_valid_ff && rsp_word_ff.msg_end && !rsp_word_ff.run_last))
   `ASSERT_NEXT(a_group_kept_until_done, clock, reset, emit && !pop, head_valid)

endmodule

FILE: src/base64_stream_encoder_core.sv
// Top level of the streaming Base64 encoder: front, group queue, back, registers.
`timescale 1ns / 1ps
// Usage
//   req_*  : one message byte per word, msg_last on the final byte of a message.
//            A word is taken on a rising edge with req_valid high and req_stall low.
//   rsp_*  : one ASCII character per word; run_last marks the last character a
//            group caused, msg_end the last character of the message.
//   csr_*  : index 0 url_alphabet (reset 0), index 1 pad_enable (reset 1);
//            written on csr_write_en high; users write only when idle, unchecked.
// A group closed by a taken byte is queued, and its characters then leave through
//   the output register one a cycle while rsp_stall is low.
// Throughput: the back emits one character a cycle while rsp_stall is low, four
//   for each full group of three bytes (two to four for a short final group).
// The front holds up to two bytes and queues closed groups (QUEUE_DEPTH deep);
//   req_stall rises only while that queue is full.
// Reset (synchronous, active high) empties the queue and the output register,
//   drops any held bytes and restores the register defaults.
// A stalled rsp word holds; the back then stops, and the front keeps taking
//   bytes until the queue fills.
module base64_stream_encoder_core
   import b64e_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  req_word_type           req_word,
   output logic                   req_stall,
   output logic                   rsp_valid,
   output rsp_word_type           rsp_word,
   input  logic                   rsp_stall,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic      url_alphabet_ff, url_alphabet_in;
   logic      pad_enable_ff,   pad_enable_in;
   logic      push;
   group_type push_group;
   logic      pop;
   logic      queue_full;
   logic      head_valid;
   group_type head_group;

   // register file
   always_comb begin
      url_alphabet_in = url_alphabet_ff;
      pad_enable_in   = pad_enable_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_URL_ALPHABET: url_alphabet_in = csr_wdata[0];
            CSR_PAD_ENABLE:   pad_enable_in   = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         url_alphabet_ff <= 1'b0;
         pad_enable_ff   <= 1'b1;
      end else begin
         url_alphabet_ff <= url_alphabet_in;
         pad_enable_ff   <= pad_enable_in;
      end
   end

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_word   (req_word),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .push       (push),
      .push_group (push_group)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_group (head_group)
   );

   b64e_back u_back (
      .clock        (clock),
      .reset        (reset),
      .url_alphabet (url_alphabet_ff),
      .pad_enable   (pad_enable_ff),
      .head_valid   (head_valid),
      .head_group   (head_group),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_word     (rsp_word),
      .rsp_stall    (rsp_stall)
   );

endmodule
